### rtl/c2s_pkg.sv
// ---------------------------------------------------------------------------
// c2s_pkg - shared constants for the cartesian to spherical converter
// Fixed-point widths, CORDIC angle table and output limits.
// ---------------------------------------------------------------------------
package c2s_pkg;

  localparam int CoordW   = 24;   // Q15.8 input coordinate
  localparam int DiffW    = 25;   // difference of two coordinates
  localparam int MagW     = 24;   // magnitude of a difference
  localparam int SqW      = 48;   // square of a magnitude
  localparam int DistW    = 25;   // distance, Q.8
  localparam int ElevW    = 18;   // elevation, Q.16 radians
  localparam int AzimW    = 19;   // azimuth, Q.16 radians
  localparam int AngInW   = 30;   // CORDIC operand width at its input
  localparam int CordicW  = 35;   // CORDIC datapath width after normalizing
  localparam int AngAccW  = 28;   // Q.24 angle accumulator
  localparam int CordicSteps = 24;
  localparam int NormSteps   = 6;
  localparam int NormLog     = 30; // normalize until magnitude reaches 2^30
  localparam int HalfPiQ24   = 26353589;
  localparam int ElevMax     = 102944;
  localparam int AzimMax     = 205887;

  function automatic logic [AngAccW-1:0] atan_q24(input int i);
    logic [AngAccW-1:0] v;
    case (i)
      0:  v = AngAccW'(13176795);
      1:  v = AngAccW'(7778716);
      2:  v = AngAccW'(4110060);
      3:  v = AngAccW'(2086331);
      4:  v = AngAccW'(1047214);
      5:  v = AngAccW'(524117);
      6:  v = AngAccW'(262123);
      7:  v = AngAccW'(131069);
      default: v = AngAccW'(32'd1 << (24 - i));
    endcase
    return v;
  endfunction

  // shift tried at each normalize step; the last step finishes the job
  function automatic int norm_shift(input int k);
    int s;
    case (k)
      0: s = 16;
      1: s = 8;
      2: s = 4;
      3: s = 2;
      default: s = 1;
    endcase
    return s;
  endfunction

endpackage

### rtl/c2s_delay.sv
// ---------------------------------------------------------------------------
// c2s_delay - stallable delay line
// Moves a word DEPTH stages forward, advancing only when en is high.
// ---------------------------------------------------------------------------
module c2s_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

### rtl/c2s_isqrt.sv
// ---------------------------------------------------------------------------
// c2s_isqrt - pipelined integer square root
// One root bit per stage; gives floor(sqrt(din)) and the remainder.
// ---------------------------------------------------------------------------
module c2s_isqrt #(
  parameter int IW = 50,
  parameter int N  = IW / 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] din,
  output logic [N-1:0]  root,
  output logic [N+1:0]  rem
);

  localparam int RW = N + 2;

  logic [IW-1:0] val   [0:N];
  logic [N-1:0]  rt    [0:N];
  logic [RW-1:0] rm    [0:N];

  assign val[0] = din;
  assign rt[0]  = '0;
  assign rm[0]  = '0;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] cur;
    logic [RW:0]   trial;

    always_comb begin
      cur   = {rm[k][RW-3:0], val[k][IW-1:IW-2]};
      trial = {1'b0, cur} - {1'b0, rt[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val[k+1] <= {val[k][IW-3:0], 2'b00};
        if (!trial[RW]) begin
          rm[k+1] <= trial[RW-1:0];
          rt[k+1] <= {rt[k][N-2:0], 1'b1};
        end else begin
          rm[k+1] <= cur;
          rt[k+1] <= {rt[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[N];
  assign rem  = rm[N];

endmodule

### rtl/c2s_cordic.sv
// ---------------------------------------------------------------------------
// c2s_cordic - pipelined atan2 by CORDIC vectoring
// Quadrant fold, staged normalize, 24 rotation stages, round and saturate.
// ---------------------------------------------------------------------------
module c2s_cordic #(
  parameter int OW    = 18,
  parameter int LIMIT = 102944
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [c2s_pkg::AngInW-1:0] y_in,
  input  logic signed [c2s_pkg::AngInW-1:0] x_in,
  output logic signed [OW-1:0]              angle
);

  localparam int IW = c2s_pkg::AngInW;
  localparam int XW = c2s_pkg::CordicW;
  localparam int ZW = c2s_pkg::AngAccW;
  localparam int NS = c2s_pkg::NormSteps;
  localparam int CS = c2s_pkg::CordicSteps;
  localparam int MW = c2s_pkg::NormLog + 2;
  localparam int TOTAL = NS + CS;

  // fold a left-half-plane vector by a quarter turn
  logic signed [IW-1:0] fx, fy, ax, ay;
  logic signed [ZW-1:0] fz;
  logic                 zero_in;

  always_comb begin
    zero_in = (x_in == '0) && (y_in == '0);
    fx = x_in;
    fy = y_in;
    fz = '0;
    if (x_in[IW-1]) begin
      if (!y_in[IW-1]) begin
        fx = y_in;
        fy = -x_in;
        fz = ZW'(c2s_pkg::HalfPiQ24);
      end else begin
        fx = -y_in;
        fy = x_in;
        fz = -ZW'(c2s_pkg::HalfPiQ24);
      end
    end
    ax = fx[IW-1] ? -fx : fx;
    ay = fy[IW-1] ? -fy : fy;
  end

  logic signed [XW-1:0] xs   [0:TOTAL];
  logic signed [XW-1:0] ys   [0:TOTAL];
  logic signed [ZW-1:0] zs   [0:TOTAL];
  logic        [MW-1:0] ms   [0:NS];
  logic                 zf   [0:TOTAL];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= XW'(fx);
      ys[0] <= XW'(fy);
      zs[0] <= fz;
      ms[0] <= (ax > ay) ? MW'(ax) : MW'(ay);
      zf[0] <= zero_in;
    end
  end

  // double until the larger magnitude reaches 2^30, in binary steps
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int B = c2s_pkg::norm_shift(k);
    localparam int T = (k == NS - 1) ? c2s_pkg::NormLog : c2s_pkg::NormLog - B;
    logic go;
    assign go = ms[k] < (MW'(1) << T);

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1] <= go ? (xs[k] <<< B) : xs[k];
        ys[k+1] <= go ? (ys[k] <<< B) : ys[k];
        ms[k+1] <= go ? (ms[k] << B) : ms[k];
        zs[k+1] <= zs[k];
        zf[k+1] <= zf[k];
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_rot
    localparam int J = NS + i;
    logic signed [XW-1:0] xsh, ysh;
    assign xsh = xs[J] >>> i;
    assign ysh = ys[J] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zf[J+1] <= zf[J];
        if (!ys[J][XW-1]) begin
          xs[J+1] <= xs[J] + ysh;
          ys[J+1] <= ys[J] - xsh;
          zs[J+1] <= zs[J] + c2s_pkg::atan_q24(i);
        end else begin
          xs[J+1] <= xs[J] - ysh;
          ys[J+1] <= ys[J] + xsh;
          zs[J+1] <= zs[J] - c2s_pkg::atan_q24(i);
        end
      end
    end
  end

  // round Q.24 to Q.16, then clamp; an all-zero input vector gives zero
  localparam int QW = ZW - 8;
  logic signed [ZW-1:0] zr;
  logic signed [QW-1:0] q;
  logic signed [OW-1:0] qs;

  always_comb begin
    zr = zs[TOTAL] + ZW'(128);
    q  = QW'(zr >>> 8);
    if (zf[TOTAL]) begin
      qs = '0;
    end else if (q > QW'(LIMIT)) begin
      qs = OW'(LIMIT);
    end else if (q < -QW'(LIMIT)) begin
      qs = -OW'(LIMIT);
    end else begin
      qs = OW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= qs;
    end
  end

endmodule

### rtl/cartesian_to_spherical.sv
// ---------------------------------------------------------------------------
// cartesian_to_spherical - polar form of the vector between two 3-D points
//
// Input stream (s_axis): one beat carries both points, six signed Q15.8
// coordinates. Output stream (m_axis): one beat per input beat with the
// distance (Q.8, rounded to nearest), elevation and azimuth (radians Q.16).
// Coincident points give all zeros.
// One beat is taken every cycle while the output is not stalled. The depth
// is set by the horizontal square root in series with the elevation CORDIC:
// difference, squares and sums, then the horizontal root, then the CORDIC
// (fold, 6 normalize, 24 rotations, round).
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls, s_axis_tready drops and every stage holds.
// Reset (rst, synchronous) clears the valid bits only; the datapath keeps
// no state between beats.
// ---------------------------------------------------------------------------
module cartesian_to_spherical (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z (24 bits each)
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance[24:0], elevation[42:25], azimuth[61:43], zero[63:62]
  output logic [63:0]  m_axis_tdata
);

  localparam int LAT = 64;
  localparam int CW  = c2s_pkg::CoordW;
  localparam int DW  = c2s_pkg::DiffW;
  localparam int SW  = c2s_pkg::SqW;
  localparam int RN  = c2s_pkg::DistW;
  localparam int HIW = SW + 10;         // (horiz << 8), padded to even
  localparam int HN  = HIW / 2;
  localparam int AW  = c2s_pkg::AngInW;

  logic           en;
  logic [LAT-1:0] vld;

  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DW'($signed(s_axis_tdata[95:72]))   - DW'($signed(s_axis_tdata[23:0]));
      dy <= DW'($signed(s_axis_tdata[119:96]))  - DW'($signed(s_axis_tdata[47:24]));
      dz <= DW'($signed(s_axis_tdata[143:120])) - DW'($signed(s_axis_tdata[71:48]));
    end
  end

  // stage 2: squares of magnitudes
  logic signed [DW-1:0] adx, ady, adz;
  logic [SW-1:0] sqx, sqy, sqz;

  assign adx = dx[DW-1] ? -dx : dx;
  assign ady = dy[DW-1] ? -dy : dy;
  assign adz = dz[DW-1] ? -dz : dz;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= SW'(adx[CW-1:0]) * SW'(adx[CW-1:0]);
      sqy <= SW'(ady[CW-1:0]) * SW'(ady[CW-1:0]);
      sqz <= SW'(adz[CW-1:0]) * SW'(adz[CW-1:0]);
    end
  end

  // stage 3: sums
  logic [SW:0]   horiz;
  logic [SW+1:0] total;

  always_ff @(posedge clk) begin
    if (en) begin
      horiz <= (SW+1)'(sqx) + (SW+1)'(sqz);
      total <= (SW+2)'(sqx) + (SW+2)'(sqz) + (SW+2)'(sqy);
    end
  end

  // distance root, then round to nearest
  logic [RN-1:0] root;
  logic [RN+1:0] rem;
  logic [RN-1:0] dist_r, dist_d;

  c2s_isqrt #(.IW(SW + 2)) u_dist_sqrt (
    .clk  (clk),
    .en   (en),
    .din  (total),
    .root (root),
    .rem  (rem)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (rem > (RN+2)'(root)) ? root + RN'(1) : root;
    end
  end

  c2s_delay #(.WIDTH(RN), .DEPTH(LAT - 3 - (SW + 2) / 2 - 1)) u_dist_dly (
    .clk  (clk),
    .en   (en),
    .din  (dist_r),
    .dout (dist_d)
  );

  // horizontal root in Q.12
  logic [HN-1:0] hroot;
  logic [HN+1:0] hrem;

  c2s_isqrt #(.IW(HIW)) u_horiz_sqrt (
    .clk  (clk),
    .en   (en),
    .din  ({1'b0, horiz, 8'd0}),
    .root (hroot),
    .rem  (hrem)
  );

  // line the differences up with the horizontal root
  logic [3*DW-1:0] dd;
  logic signed [DW-1:0] dx_d, dy_d, dz_d;

  c2s_delay #(.WIDTH(3 * DW), .DEPTH(2 + HN)) u_diff_dly (
    .clk  (clk),
    .en   (en),
    .din  ({dz, dy, dx}),
    .dout (dd)
  );

  assign dx_d = dd[DW-1:0];
  assign dy_d = dd[2*DW-1:DW];
  assign dz_d = dd[3*DW-1:2*DW];

  logic signed [AW-1:0]     ey, ex, ay, ax;
  logic signed [c2s_pkg::ElevW-1:0] elev;
  logic signed [c2s_pkg::AzimW-1:0] azim;

  assign ey = AW'(dy_d) <<< 4;
  assign ex = AW'({1'b0, hroot});
  assign ay = AW'(dx_d);
  assign ax = AW'(dz_d);

  c2s_cordic #(.OW(c2s_pkg::ElevW), .LIMIT(c2s_pkg::ElevMax)) u_elev (
    .clk   (clk),
    .en    (en),
    .y_in  (ey),
    .x_in  (ex),
    .angle (elev)
  );

  c2s_cordic #(.OW(c2s_pkg::AzimW), .LIMIT(c2s_pkg::AzimMax)) u_azim (
    .clk   (clk),
    .en    (en),
    .y_in  (ay),
    .x_in  (ax),
    .angle (azim)
  );

  assign m_axis_tdata = {2'b00, azim, elev, dist_d};

endmodule

### rtl/c2s_checker.sv
// ---------------------------------------------------------------------------
// c2s_checker - port-level checks for cartesian_to_spherical
// Watches the stream handshakes and the output beat layout.
// ---------------------------------------------------------------------------
module c2s_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  // output beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // input side accepts exactly when the output side can move
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:62] == 2'b00)
    else $error("output padding not zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a stall keeps the input side closed until the beat leaves
  a_stall_closed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_cartesian_to_spherical.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cartesian_to_spherical - stream test of the point-pair polar converter
// Sends point pairs through the input stream in random bursts, stalls the
// output stream on its own pattern and checks every beat against a
// fixed-point model of length, elevation and azimuth.
// ---------------------------------------------------------------------------
module tb_cartesian_to_spherical;

  // first member sits in the top bits, matching the output beat layout
  typedef struct packed {
    logic [c2s_pkg::AzimW-1:0] azim;
    logic [c2s_pkg::ElevW-1:0] elev;
    logic [c2s_pkg::DistW-1:0] distance;
  } polar_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;

  polar_t polar_q[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     in_burst;
  int     burst_left;
  int     stall_mode = 0;

  localparam int CycleLimit = 400000;

  cartesian_to_spherical uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vec_angle(longint y, longint x, longint lim);
    longint z, t, m, xs, ys, q;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = c2s_pkg::HalfPiQ24;
      end else begin
        x = -y; y = t; z = -c2s_pkg::HalfPiQ24;
      end
    end
    m = ((x < 0) ? -x : x) > ((y < 0) ? -y : y) ? ((x < 0) ? -x : x) : ((y < 0) ? -y : y);
    while (m < (64'sd1 <<< c2s_pkg::NormLog)) begin
      x *= 2; y *= 2; m *= 2;
    end
    for (int i = 0; i < c2s_pkg::CordicSteps; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(c2s_pkg::atan_q24(i));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(c2s_pkg::atan_q24(i));
      end
    end
    q = floor_shr(z + 128, 8);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic polar_t to_polar(logic [143:0] pts);
    longint dx, dy, dz, horiz, total, r, h;
    polar_t p;
    dx = longint'($signed(pts[95:72])) - longint'($signed(pts[23:0]));
    dy = longint'($signed(pts[119:96])) - longint'($signed(pts[47:24]));
    dz = longint'($signed(pts[143:120])) - longint'($signed(pts[71:48]));
    horiz = dx * dx + dz * dz;
    total = horiz + dy * dy;
    r = int_sqrt(total);
    if (total - r * r > r) r++;
    h = int_sqrt(horiz << 8);
    p.distance = r[c2s_pkg::DistW-1:0];
    p.elev = c2s_pkg::ElevW'(vec_angle(dy * 16, h, c2s_pkg::ElevMax));
    p.azim = c2s_pkg::AzimW'(vec_angle(dx, dz, c2s_pkg::AzimMax));
    return p;
  endfunction

  // send one point pair; the sender opens and closes bursts on its own
  task automatic send_pair(logic [23:0] fx, fy, fz, tx, ty, tz);
    while (!in_burst) begin
      @(posedge clk);
      if ($urandom_range(3) == 0) begin
        in_burst = 1;
        burst_left = $urandom_range(40, 1);
      end
    end
    s_axis_tdata  <= {tz, ty, tx, fz, fy, fx};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    polar_q.push_back(to_polar({tz, ty, tx, fz, fy, fx}));
    burst_left--;
    if (burst_left <= 0) begin
      in_burst = 0;
      s_axis_tvalid <= 1'b0;
    end
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(16)) - 24'd8;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(24'h123456, 24'hFEDCBA, 24'h00ABCD, 24'h123456, 24'hFEDCBA, 24'h00ABCD);
    send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
    // vertical vectors
    send_pair(0, 0, 0, 0, 24'h000100, 0);
    send_pair(0, 0, 0, 0, 24'hFFFF00, 0);
    send_pair(0, 24'h800000, 0, 0, 24'h7FFFFF, 0);
    // negative dz with dx zero, and other axis directions
    send_pair(0, 0, 0, 0, 0, 24'hFFFFFF);
    send_pair(0, 0, 0, 0, 0, 24'h800000);
    send_pair(0, 0, 0, 0, 0, 24'h000001);
    send_pair(0, 0, 0, 24'h000001, 0, 0);
    send_pair(0, 0, 0, 24'hFFFFFF, 0, 0);
    send_pair(0, 0, 0, 24'hFFFFFF, 0, 24'hFFFFFF);
    send_pair(0, 0, 0, 24'h000001, 24'h000001, 24'h000001);
    send_pair(0, 0, 0, 24'h7FFFFF, 24'h000001, 24'h800000);
    send_pair(0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
    send_pair(24'h000003, 0, 0, 0, 0, 24'h000004);
  endtask

  task automatic test_random();
    for (int n = 0; n < 700; n++)
      send_pair(rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord());
  endtask

  // receiver stall pattern and result check
  always @(posedge clk) begin
    polar_t exp_p, got;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[61:0];
      if (polar_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        exp_p = polar_q.pop_front();
        if (got !== exp_p || m_axis_tdata[63:62] !== 2'b00) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: dist %0d/%0d elev %0d/%0d azim %0d/%0d",
                     exp_p.distance, got.distance,
                     $signed(exp_p.elev), $signed(got.elev),
                     $signed(exp_p.azim), $signed(got.azim));
        end
      end
    end
    if ($urandom_range(63) == 0) stall_mode <= $urandom_range(2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(3) != 0);
      default: m_axis_tready <= cycles[3];
    endcase
  end

  initial begin
    in_burst = 0;
    burst_left = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (polar_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("FAIL");
    $finish;
  end
endmodule
